/* src/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg
// types, constants and microcode for the pid controller with feedforward
// ----------------------------------------------------------------------------
package pfc_pkg;

  // payload of one input transaction
  typedef struct packed {
    logic signed [15:0] measured;
    logic signed [15:0] target;
    logic [31:0]        time_ms;
    logic               clear_integral;
  } pfc_in_t;

  // payload of one result transaction
  typedef struct packed {
    logic signed [15:0] drive;
    logic signed [23:0] integral_term;
    logic signed [31:0] derivative_term;
  } pfc_out_t;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P_GAIN       = 3'd0,
    CFG_I_GAIN       = 3'd1,
    CFG_D_GAIN       = 3'd2,
    CFG_FF_GAIN      = 3'd3,
    CFG_INTEGRAL_MIN = 3'd4,
    CFG_INTEGRAL_MAX = 3'd5,
    CFG_DRIVE_MIN    = 3'd6,
    CFG_DRIVE_MAX    = 3'd7
  } cfg_idx_t;

  // datapath widths
  localparam int ERR_W  = 17;  // target - measured
  localparam int DERR_W = 18;  // error change
  localparam int T_W    = 16;  // elapsed ms once below the gap limit
  localparam int MUL_AW = 32;
  localparam int MUL_BW = 16;
  localparam int PROD_W = MUL_AW + MUL_BW;
  localparam int SUM_W  = 27;  // running drive sum
  localparam int QS_W   = 42;  // signed quotient and integral update

  // divide by the ms-per-second constant, several quotient bits a cycle
  localparam int MS_PER_SECOND = 1000;
  localparam int REM_W         = 10;
  localparam int DIV_W         = PROD_W;
  localparam int DIV_BITS      = 8;
  localparam int DIV_PASSES    = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W     = 3;

  // microcode
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_FINISH = 4'd12;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_P,   // |error| x |p_gain|
    MUL_FF,  // |target| x |ff_gain|
    MUL_I,   // |error| x |i_gain|
    MUL_D,   // |error change| x |d_gain|
    MUL_T    // previous product x elapsed ms
  } mul_op_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_PROD,  // sum += product / 256
    ACC_INT,   // integral += quotient, then clamp
    ACC_ISUM,  // sum += integral / 256
    ACC_DER,   // derivative = saturated quotient
    ACC_DSUM,  // sum += derivative / 256
    ACC_OUT    // saturate sum and load result register
  } acc_op_t;

  typedef struct packed {
    mul_op_t           mul;
    acc_op_t           acc;
    logic              div_go;
    logic              div_wait;
    logic              gap_jump;
    logic [STEP_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{mul: MUL_NONE, acc: ACC_NONE, div_go: 1'b0, div_wait: 1'b0,
          gap_jump: 1'b0, target: STEP_FINISH};
    case (step)
      4'd0: begin
        w.gap_jump = 1'b1;
        w.mul      = MUL_P;
      end
      4'd1: begin
        w.acc = ACC_PROD;
        w.mul = MUL_FF;
      end
      4'd2: begin
        w.acc = ACC_PROD;
        w.mul = MUL_I;
      end
      4'd3: w.mul = MUL_T;
      4'd4: w.div_go = 1'b1;
      4'd5: w.div_wait = 1'b1;
      4'd6: begin
        w.acc = ACC_INT;
        w.mul = MUL_D;
      end
      4'd7: begin
        w.acc = ACC_ISUM;
        w.mul = MUL_T;
      end
      4'd8: w.div_go = 1'b1;
      4'd9: w.div_wait = 1'b1;
      4'd10: w.acc = ACC_DER;
      4'd11: w.acc = ACC_DSUM;
      default: w.acc = ACC_OUT;
    endcase
    return w;
  endfunction

endpackage

/* src/pid_feedforward_controller_core.sv */
// ----------------------------------------------------------------------------
// pid_feedforward_controller_core
// microcoded pid controller with setpoint feedforward
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready/in_data): one transaction per control
//   tick with measured, target, time_ms and clear_integral
//   result channel (out_valid/out_ready/out_data): one transaction per input,
//   carrying the saturated drive, the integral accumulator and the last
//   derivative term
//   cfg port: gains, integral clamp and drive limits, written with cfg_we
//   while the block is idle
// timing
//   an item runs through the microcode steps from acceptance to out_valid and
//   jumps to the last step when the time gap is too long; in_ready rises again
//   at the same edge as out_valid, so one item is in work at a time
//   the steps hold two passes through the shared divide-by-1000 unit (load,
//   6 passes of 8 quotient bits, exit) and use one 32x16 multiplier
// reset
//   rst_n (synchronous) restores the default gains and limits and clears
//   the controller history
// stalls
//   the result register holds while out_ready is low; the next item is
//   still accepted and runs up to its last step, where it waits for the slot
// ----------------------------------------------------------------------------
module pid_feedforward_controller_core #(
  parameter int unsigned MAX_GAP_MS = 1000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pfc_pkg::pfc_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pfc_pkg::pfc_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [pfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pfc_pkg::*;

  // configuration registers
  logic signed [15:0] p_gain_r, i_gain_r, d_gain_r, ff_gain_r;
  logic signed [15:0] integral_min_r, integral_max_r, drive_min_r, drive_max_r;

  // controller history
  logic signed [ERR_W-1:0] last_error_r;
  logic [31:0]             last_time_r;
  logic signed [23:0]      integral_acc_r;
  logic signed [31:0]      derivative_last_r;

  // per-item operands
  logic signed [ERR_W-1:0]  err_r;
  logic signed [DERR_W-1:0] derr_r;
  logic signed [15:0]       tgt_r;
  logic [T_W-1:0]           t_r;
  logic                     gap_ok_r;
  logic signed [SUM_W-1:0]  sum_r;

  // sequencer
  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              fin;
  ucode_t            uc;

  // multiplier
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic              mul_neg;
  logic [PROD_W-1:0] prod_r;
  logic              neg_r;

  // divider
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [REM_W:0]       rem_x;
  logic                 div_busy;

  // result
  logic     out_valid_r;
  pfc_out_t out_r;
  logic     out_free;

  // accept-time values
  logic                     in_acc;
  logic signed [ERR_W-1:0]  err_in;
  logic [31:0]              elapsed;

  // accumulate-time values
  logic [QS_W-1:0]          q_mag;
  logic signed [QS_W-1:0]   q_s;
  logic signed [QS_W-1:0]   i_sum, i_lo, i_hi;
  logic signed [23:0]       i_new;
  logic signed [31:0]       d_new;
  logic signed [SUM_W-1:0]  prod_term;
  logic signed [SUM_W-1:0]  drive_lo, drive_hi;
  logic signed [15:0]       drive_sat;

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [DERR_W-1:0] mag18(input logic signed [DERR_W-1:0] v);
    return v[DERR_W-1] ? DERR_W'(-v) : DERR_W'(v);
  endfunction

  // truncate toward zero on divide by 256
  function automatic logic signed [SUM_W-1:0] trunc256(input logic signed [31:0] v);
    logic [31:0]             m;
    logic signed [SUM_W-1:0] s;
    m = v[31] ? 32'(-v) : 32'(v);
    s = $signed(SUM_W'(m[31:8]));
    return v[31] ? -s : s;
  endfunction

  assign in_ready  = !busy_r;
  assign in_acc    = in_valid && !busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;
  assign uc        = ucode_rom(step_r);
  assign div_busy  = div_cnt_r != '0;

  assign err_in  = ERR_W'($signed(in_data.target)) - ERR_W'($signed(in_data.measured));
  assign elapsed = in_data.time_ms - last_time_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r       <= '0;
      i_gain_r       <= '0;
      d_gain_r       <= '0;
      ff_gain_r      <= '0;
      integral_min_r <= -16'sd250;
      integral_max_r <= 16'sd250;
      drive_min_r    <= '0;
      drive_max_r    <= 16'sd255;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_P_GAIN:       p_gain_r       <= $signed(cfg_data);
        CFG_I_GAIN:       i_gain_r       <= $signed(cfg_data);
        CFG_D_GAIN:       d_gain_r       <= $signed(cfg_data);
        CFG_FF_GAIN:      ff_gain_r      <= $signed(cfg_data);
        CFG_INTEGRAL_MIN: integral_min_r <= $signed(cfg_data);
        CFG_INTEGRAL_MAX: integral_max_r <= $signed(cfg_data);
        CFG_DRIVE_MIN:    drive_min_r    <= $signed(cfg_data);
        CFG_DRIVE_MAX:    drive_max_r    <= $signed(cfg_data);
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    fin      = 1'b0;
    if (in_acc) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      priority if (uc.gap_jump && !gap_ok_r) begin
        // gap too long: skip all terms, drive sum stays zero
        step_nxt = uc.target;
      end else if (uc.div_wait && div_busy) begin
        step_nxt = step_r;
      end else if (uc.acc == ACC_OUT) begin
        // wait here until the result slot is free
        if (out_free) begin
          fin      = 1'b1;
          busy_nxt = 1'b0;
        end
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  // drive saturation, lower limit checked first
  assign drive_lo = SUM_W'(drive_min_r);
  assign drive_hi = SUM_W'(drive_max_r);
  always_comb begin
    priority if (sum_r < drive_lo) drive_sat = drive_min_r;
    else if (sum_r > drive_hi)     drive_sat = drive_max_r;
    else                           drive_sat = sum_r[15:0];
  end

  // sequencer state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (fin) begin
      out_r <= '{drive: drive_sat, integral_term: integral_acc_r,
                 derivative_term: derivative_last_r};
    end
  end

  // ---------------------------------------------------------------- multiplier
  // magnitudes in, sign carried beside the product
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = neg_r;
    unique case (uc.mul)
      MUL_NONE: begin
        mul_a = '0;
      end
      MUL_P: begin
        mul_a   = MUL_AW'(mag18(DERR_W'(err_r)));
        mul_b   = mag16(p_gain_r);
        mul_neg = err_r[ERR_W-1] ^ p_gain_r[15];
      end
      MUL_FF: begin
        mul_a   = MUL_AW'(mag16(tgt_r));
        mul_b   = mag16(ff_gain_r);
        mul_neg = tgt_r[15] ^ ff_gain_r[15];
      end
      MUL_I: begin
        mul_a   = MUL_AW'(mag18(DERR_W'(err_r)));
        mul_b   = mag16(i_gain_r);
        mul_neg = err_r[ERR_W-1] ^ i_gain_r[15];
      end
      MUL_D: begin
        mul_a   = MUL_AW'(mag18(derr_r));
        mul_b   = mag16(d_gain_r);
        mul_neg = derr_r[DERR_W-1] ^ d_gain_r[15];
      end
      MUL_T: begin
        // first-stage products stay below 2^32
        mul_a = prod_r[MUL_AW-1:0];
        mul_b = MUL_BW'(t_r);
      end
      default: mul_a = '0;
    endcase
  end

  // ---------------------------------------------------------------- divider
  // restoring division by 1000, DIV_BITS quotient bits a cycle
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    rem_x   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_x   = {rem_nxt, quo_nxt[DIV_W-1]};
      quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
      if (rem_x >= (REM_W+1)'(MS_PER_SECOND)) begin
        rem_x      = rem_x - (REM_W+1)'(MS_PER_SECOND);
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = rem_x[REM_W-1:0];
    end
  end

  // ---------------------------------------------------------------- accumulate
  assign q_mag = QS_W'(quo_r[QS_W-3:0]);
  assign q_s   = neg_r ? -$signed(q_mag) : $signed(q_mag);

  // integral update and clamp, lower limit first
  assign i_sum = QS_W'(integral_acc_r) + q_s;
  assign i_lo  = QS_W'($signed({integral_min_r, 8'h00}));
  assign i_hi  = QS_W'($signed({integral_max_r, 8'h00}));
  always_comb begin
    priority if (i_sum < i_lo) i_new = i_lo[23:0];
    else if (i_sum > i_hi)     i_new = i_hi[23:0];
    else                       i_new = i_sum[23:0];
  end

  // derivative saturates to 32 bits
  always_comb begin
    priority if (q_s < QS_W'(32'sh8000_0000)) d_new = 32'sh8000_0000;
    else if (q_s > QS_W'(32'sh7FFF_FFFF))     d_new = 32'sh7FFF_FFFF;
    else                                      d_new = q_s[31:0];
  end

  assign prod_term = neg_r ? -$signed(SUM_W'(prod_r[32:8]))
                           : $signed(SUM_W'(prod_r[32:8]));

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r      <= '0;
      last_time_r       <= '0;
      integral_acc_r    <= '0;
      derivative_last_r <= '0;
      div_cnt_r         <= '0;
    end else begin
      if (in_acc) begin
        last_error_r <= err_in;
        last_time_r  <= in_data.time_ms;
        if (in_data.clear_integral) begin
          integral_acc_r <= '0;
        end
      end else if (busy_r) begin
        if (uc.acc == ACC_INT) begin
          integral_acc_r <= i_new;
        end
        if (uc.acc == ACC_DER) begin
          derivative_last_r <= d_new;
        end
      end
      if (busy_r && uc.div_go) begin
        div_cnt_r <= DIV_CNT_W'(DIV_PASSES);
      end else if (div_busy) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
    end

    // per-item operands
    if (in_acc) begin
      err_r    <= err_in;
      derr_r   <= DERR_W'(err_in) - DERR_W'(last_error_r);
      tgt_r    <= $signed(in_data.target);
      t_r      <= elapsed[T_W-1:0];
      gap_ok_r <= elapsed < 32'(MAX_GAP_MS);
      sum_r    <= '0;
    end else if (busy_r) begin
      unique case (uc.acc)
        ACC_PROD: sum_r <= sum_r + prod_term;
        ACC_ISUM: sum_r <= sum_r + trunc256(32'(integral_acc_r));
        ACC_DSUM: sum_r <= sum_r + trunc256(derivative_last_r);
        default:  sum_r <= sum_r;
      endcase
    end

    // multiplier product
    if (busy_r && uc.mul != MUL_NONE) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
      neg_r  <= mul_neg;
    end

    // divider registers
    if (busy_r && uc.div_go) begin
      quo_r <= prod_r;
      rem_r <= '0;
    end else if (div_busy) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

/* tb/sv/tb_pid_feedforward_controller_core.sv */
// ----------------------------------------------------------------------------
// tb_pid_feedforward_controller_core
// self-checking bench for the pid controller with setpoint feedforward
// ----------------------------------------------------------------------------
// a short directed table covers reset values, gain and limit extremes, the
// long-gap path, the clear flag, timestamp wrap, inverted clamp limits and
// derivative saturation. a random part then walks several register settings
// with mostly in-gap timestamps. every result is compared field by field
// against a typed-in value or a bit-exact predictor of the control law kept
// in the bench, with random idle cycles on both the input and result channel.
// ----------------------------------------------------------------------------
module tb_pid_feedforward_controller_core;
  import pfc_pkg::*;

  localparam int     GAP_LIMIT_MS    = 1000;
  localparam int     PHASES          = 6;
  localparam int     ITEMS_PER_PHASE = 235;
  localparam int     SETTLE_CYCLES   = 30;
  localparam int     DRAIN_CYCLES    = 40;
  localparam int     WATCHDOG_LIMIT  = 1000;
  localparam longint DERIV_HI        = (64'sd1 <<< 31) - 1;
  localparam longint DERIV_LO        = -(64'sd1 <<< 31);

  typedef enum logic [1:0] {
    ROW_CFG,         // register write
    ROW_ITEM,        // input transaction, checked against the predictor
    ROW_ITEM_KNOWN   // input transaction with a typed-in result
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    idx;
    logic [15:0] val;
    pfc_in_t     stim;
    pfc_out_t    known;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  pfc_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  pfc_out_t out_data;
  logic     cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state: register shadow and controller history
  logic signed [15:0] regs_q [8];
  longint      last_err_q;
  logic [31:0] last_time_q;
  longint      integ_q;
  longint      deriv_q;

  pfc_out_t    pending_results [$];
  plan_row_t   plan [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  logic [31:0] stim_clock_ms = 32'd0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;

  pid_feedforward_controller_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // lower limit checked first; with inverted limits only values below it get the lower limit
  function automatic longint clamp_range(input longint x, input longint lo,
                                         input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // one control step; updates the history and returns the result transaction
  function automatic pfc_out_t control_law_step(input pfc_in_t x);
    longint      meas, tgt, err, t, d, sum;
    longint      kp, ki, kd, kf, imin, imax, dmin, dmax;
    logic [31:0] elapsed;
    pfc_out_t    r;
    kp   = longint'(regs_q[CFG_P_GAIN]);
    ki   = longint'(regs_q[CFG_I_GAIN]);
    kd   = longint'(regs_q[CFG_D_GAIN]);
    kf   = longint'(regs_q[CFG_FF_GAIN]);
    imin = longint'(regs_q[CFG_INTEGRAL_MIN]);
    imax = longint'(regs_q[CFG_INTEGRAL_MAX]);
    dmin = longint'(regs_q[CFG_DRIVE_MIN]);
    dmax = longint'(regs_q[CFG_DRIVE_MAX]);
    meas = longint'($signed(x.measured));
    tgt  = longint'($signed(x.target));
    err  = tgt - meas;
    elapsed = x.time_ms - last_time_q;   // wraps modulo 2^32
    sum = 0;
    if (x.clear_integral) integ_q = 0;
    // signed longint division truncates toward zero
    if (elapsed < GAP_LIMIT_MS) begin
      t = longint'(elapsed);
      sum += err * kp / 256;
      integ_q += err * ki * t / 1000;
      integ_q = clamp_range(integ_q, imin * 256, imax * 256);
      sum += integ_q / 256;
      d = (err - last_err_q) * kd * t / 1000;
      deriv_q = clamp_range(d, DERIV_LO, DERIV_HI);
      sum += deriv_q / 256;
      sum += tgt * kf / 256;
    end
    last_err_q  = err;
    last_time_q = x.time_ms;
    sum = clamp_range(sum, dmin, dmax);
    r.drive           = sum[15:0];
    r.integral_term   = integ_q[23:0];
    r.derivative_term = deriv_q[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table helpers
  // ---------------------------------------------------------------------------

  function automatic plan_row_t make_item(input int meas, input int tgt,
                                          input logic [31:0] ms, input bit clr);
    plan_row_t row;
    row.kind  = ROW_ITEM;
    row.idx   = CFG_P_GAIN;
    row.val   = '0;
    row.stim.measured       = meas[15:0];
    row.stim.target         = tgt[15:0];
    row.stim.time_ms        = ms;
    row.stim.clear_integral = clr;
    row.known = '0;
    return row;
  endfunction

  function automatic void add_cfg(input cfg_idx_t idx, input int val);
    plan_row_t row;
    row = make_item(0, 0, 32'd0, 1'b0);
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.val  = val[15:0];
    plan.push_back(row);
  endfunction

  function automatic void add_item(input int meas, input int tgt,
                                   input logic [31:0] ms, input bit clr);
    plan.push_back(make_item(meas, tgt, ms, clr));
  endfunction

  function automatic void add_known(input int meas, input int tgt,
                                    input logic [31:0] ms, input int drv,
                                    input int integ, input int deriv);
    plan_row_t row;
    row = make_item(meas, tgt, ms, 1'b0);
    row.kind = ROW_ITEM_KNOWN;
    row.known.drive           = drv[15:0];
    row.known.integral_term   = integ[23:0];
    row.known.derivative_term = deriv;
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // random draws
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] draw_gain();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 65535);
      1: begin
        case ($urandom_range(0, 2))
          0: v = -32768;
          1: v = 32767;
          default: v = 0;
        endcase
      end
      default: v = $urandom_range(0, 1024) - 512;  // around +/-2.0
    endcase
    return v[15:0];
  endfunction

  task automatic draw_limits(output logic [15:0] lo, output logic [15:0] hi);
    int a, b;
    case ($urandom_range(0, 5))
      0: begin   // inverted
        a = $urandom_range(0, 500);
        b = -$urandom_range(0, 500);
      end
      1: begin   // full range
        a = -32768;
        b = 32767;
      end
      2: begin   // narrow window
        a = $urandom_range(0, 200) - 100;
        b = a + $urandom_range(0, 50);
      end
      default: begin
        a = -$urandom_range(0, 3000);
        b = $urandom_range(0, 3000);
      end
    endcase
    lo = a[15:0];
    hi = b[15:0];
  endtask

  // timestamps mostly advance inside the gap limit so the full pid path runs
  function automatic pfc_in_t draw_item();
    pfc_in_t x;
    int      base;
    case ($urandom_range(0, 9))
      0: stim_clock_ms = $urandom;                                 // jump anywhere
      1: stim_clock_ms += $urandom_range(GAP_LIMIT_MS, 70000);     // gap too long
      2: begin
        case ($urandom_range(0, 2))
          0: stim_clock_ms += GAP_LIMIT_MS - 1;
          1: stim_clock_ms += GAP_LIMIT_MS;
          default: stim_clock_ms += 0;
        endcase
      end
      default: stim_clock_ms += $urandom_range(0, GAP_LIMIT_MS - 1);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      x.measured = 16'($urandom_range(0, 65535));
      x.target   = 16'($urandom_range(0, 65535));
    end else begin
      base = $urandom_range(0, 4000) - 2000;
      x.target   = 16'(base);
      x.measured = 16'(base + $urandom_range(0, 400) - 200);
    end
    x.time_ms        = stim_clock_ms;
    x.clear_integral = ($urandom_range(0, 9) == 0);
    return x;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers; every task starts and ends on a rising edge
  // ---------------------------------------------------------------------------

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    regs_q[idx] = val;
  endtask

  // one input transaction; the expectation is queued at acceptance
  task automatic send_item(input pfc_in_t x, input bit use_known,
                           input pfc_out_t known);
    int       gap;
    pfc_out_t predicted;
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = control_law_step(x);
    pending_results.push_back(use_known ? known : predicted);
  endtask

  // block idle: nothing outstanding and the datapath drained
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] lo, hi;
    bit          cfg_open;
    pfc_out_t    none;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_data  <= '0;
    cfg_open  = 1'b0;
    none      = '0;

    // reset values of the register shadow and the history
    regs_q[CFG_P_GAIN]       = 16'sd0;
    regs_q[CFG_I_GAIN]       = 16'sd0;
    regs_q[CFG_D_GAIN]       = 16'sd0;
    regs_q[CFG_FF_GAIN]      = 16'sd0;
    regs_q[CFG_INTEGRAL_MIN] = -16'sd250;
    regs_q[CFG_INTEGRAL_MAX] = 16'sd250;
    regs_q[CFG_DRIVE_MIN]    = 16'sd0;
    regs_q[CFG_DRIVE_MAX]    = 16'sd255;
    last_err_q  = 0;
    last_time_q = 32'd0;
    integ_q     = 0;
    deriv_q     = 0;

    // first step after reset lands past the gap limit: everything stays zero
    add_known(0, 0, 32'd5000, 0, 0, 0);
    // all gains zero at reset, drive stays at the default lower limit
    add_known(100, -100, 32'd5010, 0, 0, 0);
    // unity proportional gain: drive follows the error, then hits both limits
    add_cfg(CFG_P_GAIN, 256);
    add_known(0, 100, 32'd5020, 100, 0, 0);
    add_known(-32768, 32767, 32'd5030, 255, 0, 0);
    add_known(32767, -32768, 32'd5040, 0, 0, 0);
    // extreme gains on the integral, derivative and feedforward terms
    add_cfg(CFG_I_GAIN, 32767);
    add_cfg(CFG_D_GAIN, -32768);
    add_cfg(CFG_FF_GAIN, -32768);
    add_item(-32768, 32767, 32'd6039, 1'b0);     // longest in-gap step
    add_item(32767, -32768, 32'd6040, 1'b1);     // clear the integral first
    add_item(0, 500, 32'd7040, 1'b0);            // gap of exactly the limit
    add_item(1000, -1000, 32'hFFFF_FFF0, 1'b0);
    add_item(-1000, 1000, 32'h0000_0010, 1'b0);  // timestamp wraps
    add_item(-1000, 1000, 32'h0000_0010, 1'b0);  // zero elapsed
    // inverted integral and drive limits
    add_cfg(CFG_INTEGRAL_MIN, 100);
    add_cfg(CFG_INTEGRAL_MAX, -100);
    add_cfg(CFG_DRIVE_MIN, 32767);
    add_cfg(CFG_DRIVE_MAX, -32768);
    add_item(5, -5, 32'h0000_0020, 1'b0);
    add_item(-5, 5, 32'h0000_0030, 1'b1);
    // full-range limits, derivative saturates high and then low
    add_cfg(CFG_INTEGRAL_MIN, -32768);
    add_cfg(CFG_INTEGRAL_MAX, 32767);
    add_cfg(CFG_DRIVE_MIN, -32768);
    add_cfg(CFG_DRIVE_MAX, 32767);
    add_item(-32768, 32767, 32'h0000_0100, 1'b0);
    add_item(32767, -32768, 32'h0000_04E7, 1'b0);
    add_item(-32768, 32767, 32'h0000_08CE, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        if (cfg_open) begin
          cfg_we   <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(plan[k].stim, plan[k].kind == ROW_ITEM_KNOWN, plan[k].known);
      end
    end

    // random phases, each with its own register setting
    stim_clock_ms = 32'h0000_08CE;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_reg(CFG_P_GAIN, draw_gain());
      write_reg(CFG_I_GAIN, draw_gain());
      write_reg(CFG_D_GAIN, draw_gain());
      write_reg(CFG_FF_GAIN, draw_gain());
      draw_limits(lo, hi);
      write_reg(CFG_INTEGRAL_MIN, lo);
      write_reg(CFG_INTEGRAL_MAX, hi);
      draw_limits(lo, hi);
      write_reg(CFG_DRIVE_MIN, lo);
      write_reg(CFG_DRIVE_MAX, hi);
      cfg_we <= 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(draw_item(), 1'b0, none);
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random stalls, compare against the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin
    int       gap;
    pfc_out_t want;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      gap = calm_out ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      // out_data sampled at the accepting edge
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with nothing expected, drive %0d",
                 $time, $signed(out_data.drive));
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.drive !== want.drive) begin
          $display("%0t: drive expected %0d actual %0d", $time,
                   $signed(want.drive), $signed(out_data.drive));
          fail_count++;
        end
        if (out_data.integral_term !== want.integral_term) begin
          $display("%0t: integral_term expected %0d actual %0d", $time,
                   $signed(want.integral_term), $signed(out_data.integral_term));
          fail_count++;
        end
        if (out_data.derivative_term !== want.derivative_term) begin
          $display("%0t: derivative_term expected %0d actual %0d", $time,
                   $signed(want.derivative_term), $signed(out_data.derivative_term));
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transaction or register write
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

/* pid_feedforward_controller_core.f */
src/pfc_pkg.sv
src/pid_feedforward_controller_core.sv
tb/sv/tb_pid_feedforward_controller_core.sv
